// ----- hdl/fls_pkg.sv -----
// package: shared types and constants for the frame free-list stack
`timescale 1ns / 1ps
package fls_pkg;

   localparam int ADDR_W  = 28;
   localparam int CNT_W   = 13;
   localparam int WANT_W  = 7;
   localparam int BYTES_W = 17;
   localparam int CSR_W   = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] ACT_REBUILD = 2'd0;
   localparam logic [1:0] ACT_ALLOC   = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BYTES = 1'b1;

   localparam logic [CNT_W-1:0]   FRAME_COUNT_RESET = 13'd4096;
   localparam logic [BYTES_W-1:0] FRAME_BYTES_RESET = 17'd4096;

   typedef struct packed {
      logic [1:0]        action;
      logic [WANT_W-1:0] want_count;
      logic [ADDR_W-1:0] release_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_addr;
      logic              addr_valid;
      logic              last;
      logic [CNT_W-1:0]  free_count;
      logic              dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_POP,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;
      logic fill_step;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       lim_zero;
      logic       alloc_zero;
      logic       fill_last;
      logic       remain_zero;
   } status_type;

endpackage

// ----- hdl/fls_ram.sv -----
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module fls_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fls_ctrl.sv -----
// controller state machine for the frame free-list stack
`timescale 1ns / 1ps
module fls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  fls_pkg::status_type  status,
   output fls_pkg::cmd_type     cmd
);

   fls_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fls_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (status.action)
                  fls_pkg::ACT_REBUILD:
                     state_in = status.lim_zero ? fls_pkg::ST_RESULT : fls_pkg::ST_FILL;
                  fls_pkg::ACT_ALLOC:
                     state_in = status.alloc_zero ? fls_pkg::ST_RESULT : fls_pkg::ST_POP;
                  default:
                     state_in = fls_pkg::ST_RESULT;
               endcase
            end
         end
         fls_pkg::ST_FILL: begin
            if (status.fill_last) begin
               state_in = fls_pkg::ST_RESULT;
            end
         end
         fls_pkg::ST_POP: begin
            state_in = fls_pkg::ST_RESULT;
         end
         fls_pkg::ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = status.remain_zero ? fls_pkg::ST_IDLE : fls_pkg::ST_POP;
            end
         end
         default: begin
            state_in = fls_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         fls_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         fls_pkg::ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         fls_pkg::ST_POP: begin
            cmd.pop = 1'b1;
         end
         fls_pkg::ST_RESULT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   // an accepted transaction always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != fls_pkg::ST_IDLE))
      else $error("accepted request did not leave idle");

   // the final result returns the controller to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && status.remain_zero) |=> (state_ff == fls_pkg::ST_IDLE))
      else $error("final result did not return to idle");
`endif

endmodule

// ----- hdl/fls_datapath.sv -----
// datapath: config registers, stack top, fill sweep and stack memory
`timescale 1ns / 1ps
module fls_datapath #(
   parameter int MAX_FRAMES = 4096,
   parameter int MAX_BURST  = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [fls_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fls_pkg::CSR_W-1:0]       csr_write_data,
   input  fls_pkg::req_type                req_payload,
   output fls_pkg::rsp_type                rsp_payload,
   input  fls_pkg::cmd_type                cmd,
   output fls_pkg::status_type             status
);

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int CW = fls_pkg::CNT_W;
   localparam int WW = fls_pkg::WANT_W;
   localparam int DW = fls_pkg::ADDR_W;
   localparam int BW = fls_pkg::BYTES_W;

   logic [CW-1:0] frame_count_ff, frame_count_in;
   logic [BW-1:0] frame_bytes_ff, frame_bytes_in;
   logic [CW-1:0] top_ff, top_in;
   logic [WW-1:0] remain_ff, remain_in;
   logic [AW-1:0] fill_idx_ff, fill_idx_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic          addr_valid_ff, addr_valid_in;
   logic          last_ff, last_in;
   logic          dropped_ff, dropped_in;

   logic [CW-1:0] lim;
   logic [WW-1:0] want_burst;
   logic [WW-1:0] want_clamp;
   logic          release_full;
   logic          push;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [DW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [DW-1:0] ram_rd_data;

   // frames in use: config count capped by the stack depth
   always_comb begin
      if (32'(frame_count_ff) > 32'(MAX_FRAMES)) begin
         lim = CW'(MAX_FRAMES);
      end else begin
         lim = frame_count_ff;
      end
   end

   always_comb begin
      if (req_payload.want_count > WW'(MAX_BURST)) begin
         want_burst = WW'(MAX_BURST);
      end else begin
         want_burst = req_payload.want_count;
      end
      if (CW'(want_burst) > top_ff) begin
         want_clamp = WW'(top_ff);
      end else begin
         want_clamp = want_burst;
      end
   end

   assign release_full = !(top_ff < lim);
   assign push = cmd.start && (req_payload.action == fls_pkg::ACT_RELEASE) && !release_full;

   assign status.action      = req_payload.action;
   assign status.lim_zero    = (lim == '0);
   assign status.alloc_zero  = (want_clamp == '0);
   assign status.fill_last   = ((32'(fill_idx_ff) + 32'd1) == 32'(lim));
   assign status.remain_zero = (remain_ff == '0);

   always_comb begin
      frame_count_in = frame_count_ff;
      frame_bytes_in = frame_bytes_ff;
      if (csr_write_enable) begin
         case (csr_index)
            fls_pkg::CSR_FRAME_COUNT: frame_count_in = csr_write_data[CW-1:0];
            fls_pkg::CSR_FRAME_BYTES: frame_bytes_in = csr_write_data[BW-1:0];
            default: frame_count_in = frame_count_ff;
         endcase
      end
   end

   always_comb begin
      top_in        = top_ff;
      remain_in     = remain_ff;
      fill_idx_in   = fill_idx_ff;
      acc_in        = acc_ff;
      addr_valid_in = addr_valid_ff;
      last_in       = last_ff;
      dropped_in    = dropped_ff;
      if (cmd.start) begin
         remain_in     = '0;
         fill_idx_in   = '0;
         acc_in        = '0;
         addr_valid_in = 1'b0;
         last_in       = 1'b1;
         dropped_in    = 1'b0;
         case (req_payload.action)
            fls_pkg::ACT_REBUILD: begin
               top_in = lim;
            end
            fls_pkg::ACT_ALLOC: begin
               remain_in = want_clamp;
            end
            fls_pkg::ACT_RELEASE: begin
               if (release_full) begin
                  dropped_in = 1'b1;
               end else begin
                  top_in = top_ff + CW'(1);
               end
            end
            default: begin
               dropped_in = 1'b0;
            end
         endcase
      end
      if (cmd.fill_step) begin
         // running sum stands in for index times frame size, wrapping at 28 bits
         fill_idx_in = fill_idx_ff + AW'(1);
         acc_in      = acc_ff + DW'(frame_bytes_ff);
      end
      if (cmd.pop) begin
         top_in        = top_ff - CW'(1);
         remain_in     = remain_ff - WW'(1);
         addr_valid_in = 1'b1;
         last_in       = (remain_ff == WW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= fls_pkg::FRAME_COUNT_RESET;
         frame_bytes_ff <= fls_pkg::FRAME_BYTES_RESET;
         top_ff         <= '0;
         remain_ff      <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         frame_bytes_ff <= frame_bytes_in;
         top_ff         <= top_in;
         remain_ff      <= remain_in;
      end
      fill_idx_ff   <= fill_idx_in;
      acc_ff        <= acc_in;
      addr_valid_ff <= addr_valid_in;
      last_ff       <= last_in;
      dropped_ff    <= dropped_in;
   end

   assign ram_wr_en   = cmd.fill_step || push;
   assign ram_wr_addr = cmd.fill_step ? fill_idx_ff : AW'(top_ff);
   assign ram_wr_data = cmd.fill_step ? acc_ff : req_payload.release_addr;
   assign ram_rd_addr = AW'(top_ff - CW'(1));

   fls_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_FRAMES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.pop),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // read data holds until the next pop, so the result can come straight off the ram
   assign rsp_payload.frame_addr = addr_valid_ff ? ram_rd_data : '0;
   assign rsp_payload.addr_valid = addr_valid_ff;
   assign rsp_payload.last       = last_ff;
   assign rsp_payload.free_count = top_ff;
   assign rsp_payload.dropped    = dropped_ff;

`ifndef NO_ASSERTIONS
   // stack top never passes the memory depth
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) <= 32'(MAX_FRAMES))
      else $error("stack top beyond memory depth");

   // a pop never happens on an empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (top_ff != '0))
      else $error("pop from empty stack");
`endif

endmodule

// ----- hdl/frame_free_list_stack.sv -----
// top level: frame free-list stack manager
// release, unused, and empty rebuild or allocate give their result in the cycle after acceptance
// rebuild writes one stack entry a cycle, one for each frame in use, then gives its result
// allocate: each address is a stack ram read, then a result
// one transaction in flight; the next is taken the cycle after the last result leaves
// reset: list empty, frame count and frame size at 4096; stack ram is not cleared
`timescale 1ns / 1ps
module frame_free_list_stack #(
   parameter int MAX_FRAMES = 4096,
   parameter int MAX_BURST  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [fls_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fls_pkg::CSR_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fls_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fls_pkg::rsp_type              rsp_payload
);

   fls_pkg::cmd_type    cmd;
   fls_pkg::status_type status;

   fls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fls_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .MAX_BURST  (MAX_BURST)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .rsp_payload      (rsp_payload),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
